// File: hdl/scdt_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the seconds-to-calendar pipeline.
// No dependencies; imported by every scdt module and the top level.
package scdt_pkg;

   localparam logic [22:0] DAY_RECIP    = 23'd6362914;  // floor(2^32 / 675)
   localparam logic [9:0]  DAY_ODD      = 10'd675;      // 86400 / 128
   localparam logic [15:0] CENTURY_DAYS = 16'd36525;
   localparam logic [13:0] BLOCK_RECIP  = 14'd11483;    // floor(2^24 / 1461)
   localparam logic [10:0] BLOCK_DAYS   = 11'd1461;
   localparam logic [10:0] HOUR_RECIP   = 11'd1165;     // floor(2^22 / 3600)
   localparam logic [11:0] HOUR_SECS    = 12'd3600;
   localparam logic [10:0] MIN_RECIP    = 11'd1092;     // floor(2^16 / 60)
   localparam logic [5:0]  MIN_SECS     = 6'd60;
   localparam logic [11:0] BASE_YEAR    = 12'd2000;
   localparam logic [11:0] OVF_YEAR     = 12'd2100;
   localparam logic [8:0]  LEAP_DAYS    = 9'd366;
   localparam logic [9:0]  COMMON_DAYS  = 10'd365;
   localparam logic [3:0]  MONTHS       = 4'd12;

   typedef struct packed {
      logic [15:0] days;
      logic [16:0] rem;
   } day_type;

   typedef struct packed {
      logic [5:0]  block;
      logic [10:0] day_in_block;
      logic [4:0]  hour;
      logic [11:0] hour_rem;
      logic        overflow;
   } split_type;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic        overflow;
   } result_type;

   // first day of month (0 = January) within the year
   function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
      logic [8:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && idx >= 4'd2) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

endpackage

// File: hdl/seconds_to_calendar_datetime_top.sv
`timescale 1ns / 1ps
// Seconds since 2000-01-01 00:00:00 to calendar date and time, six-stage pipeline.
// Throughput: one request per cycle; each stage holds its item under backpressure.
// Reset: synchronous, active high; clears every stage valid bit, no other state.
// Depends on scdt_pkg, scdt_day_div, scdt_block_div and scdt_calendar.
module seconds_to_calendar_datetime_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] seconds_since_2000
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // year[11:0] month[15:12] day[20:16] hour[25:21]
                                    // minute[31:26] second[37:32] zero[39:38]
   output logic [0:0]  rsp_tuser    // [0] overflow
);
   import scdt_pkg::*;

   logic       day_valid;
   logic       day_ready;
   day_type    day_data;
   logic       split_valid;
   logic       split_ready;
   split_type  split_data;
   result_type rsp_data;

   scdt_day_div u_day_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_seconds (req_tdata),
      .out_valid  (day_valid),
      .out_ready  (day_ready),
      .out_data   (day_data)
   );

   scdt_block_div u_block_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (day_valid),
      .in_ready  (day_ready),
      .in_data   (day_data),
      .out_valid (split_valid),
      .out_ready (split_ready),
      .out_data  (split_data)
   );

   scdt_calendar u_calendar (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (split_valid),
      .in_ready  (split_ready),
      .in_data   (split_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_data)
   );

   assign rsp_tdata = {2'b00, rsp_data.second, rsp_data.minute, rsp_data.hour,
                       rsp_data.day, rsp_data.month, rsp_data.year};
   assign rsp_tuser = rsp_data.overflow;

endmodule

// File: hdl/scdt_day_div.sv
`timescale 1ns / 1ps
// Two-stage split of the seconds count into whole days and seconds of day.
// Depends on scdt_pkg.
module scdt_day_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [31:0]        in_seconds,
   output logic               out_valid,
   input  logic               out_ready,
   output scdt_pkg::day_type  out_data
);
   import scdt_pkg::*;

   logic        s1_valid_ff;
   logic [24:0] s1_hi_ff;
   logic [6:0]  s1_lo_ff;
   logic [15:0] s1_qest_ff;
   logic        s2_valid_ff;
   day_type     s2_data_ff;
   logic        s1_ready;
   logic        s2_ready;
   logic [47:0] s1_prod;
   logic [25:0] s2_back;
   logic [10:0] s2_rem_raw;
   day_type     s2_data_in;

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   assign s1_prod = {23'd0, in_seconds[31:7]} * {25'd0, DAY_RECIP};

   always_comb begin
      s2_back    = {10'd0, s1_qest_ff} * {16'd0, DAY_ODD};
      s2_rem_raw = 11'({1'b0, s1_hi_ff} - s2_back);
      if (s2_rem_raw >= {1'b0, DAY_ODD}) begin
         s2_data_in.days = s1_qest_ff + 16'd1;
         s2_rem_raw      = s2_rem_raw - {1'b0, DAY_ODD};
      end else begin
         s2_data_in.days = s1_qest_ff;
      end
      s2_data_in.rem = {s2_rem_raw[9:0], s1_lo_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_hi_ff   <= in_seconds[31:7];
         s1_lo_ff   <= in_seconds[6:0];
         s1_qest_ff <= s1_prod[47:32];
      end
      if (s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// File: hdl/scdt_block_div.sv
`timescale 1ns / 1ps
// Two-stage split of days into four-year blocks and of the day's seconds into hours.
// Depends on scdt_pkg.
module scdt_block_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  scdt_pkg::day_type    in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output scdt_pkg::split_type  out_data
);
   import scdt_pkg::*;

   logic        s1_valid_ff;
   logic [15:0] s1_days_ff;
   logic [16:0] s1_rem_ff;
   logic [5:0]  s1_block_ff;
   logic [4:0]  s1_hour_ff;
   logic        s1_ovf_ff;
   logic        s2_valid_ff;
   split_type   s2_data_ff;
   logic        s1_ready;
   logic        s2_ready;
   logic [29:0] s1_bprod;
   logic [27:0] s1_hprod;
   logic [16:0] s2_dback;
   logic [16:0] s2_hback;
   logic [11:0] s2_d_raw;
   logic [12:0] s2_h_raw;
   split_type   s2_data_in;

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   assign s1_bprod = {14'd0, in_data.days} * {16'd0, BLOCK_RECIP};
   assign s1_hprod = {11'd0, in_data.rem} * {17'd0, HOUR_RECIP};

   always_comb begin
      s2_dback = {11'd0, s1_block_ff} * {6'd0, BLOCK_DAYS};
      s2_hback = {12'd0, s1_hour_ff} * {5'd0, HOUR_SECS};
      s2_d_raw = 12'({1'b0, s1_days_ff} - s2_dback);
      s2_h_raw = 13'(s1_rem_ff - s2_hback);
      if (s2_d_raw >= {1'b0, BLOCK_DAYS}) begin
         s2_data_in.block = s1_block_ff + 6'd1;
         s2_d_raw         = s2_d_raw - {1'b0, BLOCK_DAYS};
      end else begin
         s2_data_in.block = s1_block_ff;
      end
      if (s2_h_raw >= {1'b0, HOUR_SECS}) begin
         s2_data_in.hour = s1_hour_ff + 5'd1;
         s2_h_raw        = s2_h_raw - {1'b0, HOUR_SECS};
      end else begin
         s2_data_in.hour = s1_hour_ff;
      end
      s2_data_in.day_in_block = s2_d_raw[10:0];
      s2_data_in.hour_rem     = s2_h_raw[11:0];
      s2_data_in.overflow     = s1_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_days_ff  <= in_data.days;
         s1_rem_ff   <= in_data.rem;
         s1_block_ff <= s1_bprod[29:24];
         s1_hour_ff  <= s1_hprod[26:22];
         s1_ovf_ff   <= (in_data.days >= CENTURY_DAYS);
      end
      if (s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// File: hdl/scdt_calendar.sv
`timescale 1ns / 1ps
// Two-stage year, month, day and minute, second resolution with overflow clamp.
// Depends on scdt_pkg.
module scdt_calendar (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  scdt_pkg::split_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output scdt_pkg::result_type  out_data
);
   import scdt_pkg::*;

   logic        s1_valid_ff;
   logic [11:0] s1_year_ff;
   logic [8:0]  s1_dy_ff;
   logic        s1_leap_ff;
   logic [4:0]  s1_hour_ff;
   logic [11:0] s1_hrem_ff;
   logic [5:0]  s1_min_ff;
   logic        s1_ovf_ff;
   logic        s2_valid_ff;
   result_type  s2_data_ff;
   logic        s1_ready;
   logic        s2_ready;
   logic [11:0] s1_year_in;
   logic [8:0]  s1_dy_in;
   logic        s1_leap_in;
   logic [22:0] s1_mprod;
   result_type  s2_data_in;

   assign s2_ready = ~s2_valid_ff | out_ready;
   assign s1_ready = ~s1_valid_ff | s2_ready;
   assign in_ready = s1_ready;

   assign s1_mprod = {11'd0, in_data.hour_rem} * {12'd0, MIN_RECIP};

   always_comb begin
      logic [10:0] rest;
      logic [1:0]  yoff;
      rest = in_data.day_in_block - {2'd0, LEAP_DAYS};
      if (in_data.day_in_block < {2'd0, LEAP_DAYS}) begin
         yoff       = 2'd0;
         s1_leap_in = 1'b1;
         s1_dy_in   = in_data.day_in_block[8:0];
      end else if (rest < {1'b0, COMMON_DAYS}) begin
         yoff       = 2'd1;
         s1_leap_in = 1'b0;
         s1_dy_in   = rest[8:0];
      end else if (rest < {COMMON_DAYS, 1'b0}) begin
         yoff       = 2'd2;
         s1_leap_in = 1'b0;
         s1_dy_in   = 9'(rest - {1'b0, COMMON_DAYS});
      end else begin
         yoff       = 2'd3;
         s1_leap_in = 1'b0;
         s1_dy_in   = 9'(rest - {COMMON_DAYS, 1'b0});
      end
      s1_year_in = BASE_YEAR + {4'd0, in_data.block, 2'd0} + {10'd0, yoff};
   end

   always_comb begin
      logic [3:0] midx;
      logic [6:0] sec_raw;
      logic [5:0] minute;
      midx = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (s1_dy_ff >= month_start(4'(k), s1_leap_ff)) begin
            midx = midx + 4'd1;
         end
      end
      sec_raw = 7'({1'b0, s1_hrem_ff} - ({7'd0, s1_min_ff} * {7'd0, MIN_SECS}));
      minute  = s1_min_ff;
      if (sec_raw >= {1'b0, MIN_SECS}) begin
         minute  = minute + 6'd1;
         sec_raw = sec_raw - {1'b0, MIN_SECS};
      end
      if (s1_ovf_ff) begin
         s2_data_in.year   = OVF_YEAR;
         s2_data_in.month  = 4'd1;
         s2_data_in.day    = 5'd1;
         s2_data_in.hour   = 5'd0;
         s2_data_in.minute = 6'd0;
         s2_data_in.second = 6'd0;
      end else begin
         s2_data_in.year   = s1_year_ff;
         s2_data_in.month  = midx + 4'd1;
         s2_data_in.day    = 5'(s1_dy_ff - month_start(midx, s1_leap_ff) + 9'd1);
         s2_data_in.hour   = s1_hour_ff;
         s2_data_in.minute = minute;
         s2_data_in.second = sec_raw[5:0];
      end
      s2_data_in.overflow = s1_ovf_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= in_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_year_ff <= s1_year_in;
         s1_dy_ff   <= s1_dy_in;
         s1_leap_ff <= s1_leap_in;
         s1_hour_ff <= in_data.hour;
         s1_hrem_ff <= in_data.hour_rem;
         s1_min_ff  <= s1_mprod[21:16];
         s1_ovf_ff  <= in_data.overflow;
      end
      if (s2_ready) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule
